// File: rtl/core/lobm_pkg.sv
`default_nettype none
package lobm_pkg;

  localparam int unsigned ORDER_SLOTS_DEF = 256;
  localparam int unsigned ID_W    = 64;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned QTY_W   = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned COUNT_W = 9;
  // slot entry: side, id, price, qty, stamp
  localparam int unsigned ENTRY_W = 1 + ID_W + PRICE_W + QTY_W + STAMP_W;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_CANCEL = 1'b1;
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef enum logic [1:0] {
    ST_ADD_DONE  = 2'd0,
    ST_CXL_DONE  = 2'd1,
    ST_CXL_ABSNT = 2'd2,
    ST_ADD_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_FILL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 side;
    logic [ID_W-1:0]      id;
    logic [PRICE_W-1:0]   price;
    logic [QTY_W-1:0]     qty;
    logic [STAMP_W-1:0]   stamp;
  } entry_t;

endpackage
`default_nettype wire

// File: rtl/core/lobm_ram.sv
`default_nettype none
module lobm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/limit_order_book_matcher_core.sv
// channel  | ports                                   | handshake
// command  | op side price quantity order_id         | start & !busy
// result   | status filled_qty rested_qty bid/ask_ct | done, one cycle
//
// An item takes one scan of all ORDER_SLOTS entries through the slot memory
// (one entry a cycle, registered read) per fill, one S_FILL write back per
// fill, and the closing state S_DONE before done.
// The free slot is found during the last scan. done is registered from
// S_DONE, so busy is low in the same cycle that done is high.
// Reset is synchronous and clears the used bits at once.
// The receiver cannot stall: done is high for one cycle per item.
`default_nettype none
module limit_order_book_matcher_core
  import lobm_pkg::*;
#(
  parameter int unsigned ORDER_SLOTS = ORDER_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               op,
  input  wire logic               side,
  input  wire logic [PRICE_W-1:0] price,
  input  wire logic [QTY_W-1:0]   quantity,
  input  wire logic [ID_W-1:0]    order_id,
  output logic                    done,
  output logic [1:0]              status,
  output logic [QTY_W-1:0]        filled_qty,
  output logic [QTY_W-1:0]        rested_qty,
  output logic [COUNT_W-1:0]      bid_count,
  output logic [COUNT_W-1:0]      ask_count
);

  localparam int unsigned AW = $clog2(ORDER_SLOTS);
  localparam int unsigned CW = $clog2(ORDER_SLOTS + 1);

  state_t state, state_next;

  // request registers
  logic               r_op, r_side;
  logic [PRICE_W-1:0] r_price;
  logic [QTY_W-1:0]   left;
  logic [ID_W-1:0]    r_id;
  logic [QTY_W-1:0]   filled;

  // valid bits in flip-flops, entries in memory
  logic [ORDER_SLOTS-1:0] used;
  logic [STAMP_W-1:0]     arrival;
  logic [CW-1:0]          bid_total, ask_total;

  // scan state
  logic [AW-1:0]      raddr, rd_idx;
  logic               rd_vld;
  logic               best_vld;
  logic [AW-1:0]      best_idx;
  logic [PRICE_W-1:0] best_price;
  logic [STAMP_W-1:0] best_age;
  logic [QTY_W-1:0]   best_qty;
  logic               best_side;
  logic [ID_W-1:0]    best_id;
  logic [STAMP_W-1:0] best_stamp;
  logic               free_vld;
  logic [AW-1:0]      free_idx;

  entry_t rdata, wentry;
  logic   we;
  logic [AW-1:0] waddr;

  lobm_ram #(.WIDTH(ENTRY_W), .DEPTH(ORDER_SLOTS)) u_slots (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wentry),
    .raddr(raddr),
    .rdata(rdata)
  );

  // evaluate the entry coming out of memory
  logic [STAMP_W-1:0] age;
  logic ent_used, cand, better;
  assign ent_used = rd_vld && used[rd_idx];
  assign age = arrival - rdata.stamp;
  always_comb begin
    cand   = 1'b0;
    better = 1'b0;
    if (r_op == OP_CANCEL) begin
      cand   = ent_used && (rdata.id == r_id);
      better = !best_vld || (age < best_age);
    end else begin
      cand = ent_used && (rdata.side != r_side) &&
             ((r_side == SIDE_BUY) ? (rdata.price <= r_price)
                                   : (rdata.price >= r_price));
      if (!best_vld) better = 1'b1;
      else if (rdata.price != best_price)
        better = (r_side == SIDE_BUY) ? (rdata.price < best_price)
                                      : (rdata.price > best_price);
      else better = age > best_age;
    end
  end

  logic [QTY_W-1:0] trade;
  assign trade = (left < best_qty) ? left : best_qty;
  // the last entry of the scan still counts as a match
  logic fill_go;
  assign fill_go = (best_vld || cand) && (r_op == OP_ADD) && (left != '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (start) state_next = S_SCAN;
      S_SCAN:      if (raddr == AW'(ORDER_SLOTS - 1)) state_next = S_SCAN_LAST;
      S_SCAN_LAST: state_next = fill_go ? S_FILL : S_DONE;
      S_FILL:      state_next = (left == trade) ? S_DONE : S_SCAN;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy   = (state != S_IDLE);
    we     = 1'b0;
    waddr  = best_idx;
    wentry.side  = best_side;
    wentry.id    = best_id;
    wentry.price = best_price;
    wentry.qty   = best_qty - trade;
    wentry.stamp = best_stamp;
    unique case (state)
      S_FILL: we = 1'b1;
      S_DONE: begin
        waddr        = free_idx;
        wentry.side  = r_side;
        wentry.id    = r_id;
        wentry.price = r_price;
        wentry.qty   = left;
        wentry.stamp = arrival;
        we = (r_op == OP_ADD) && (left != '0) && free_vld;
      end
      default: ;
    endcase
  end

  // drop helper counts
  function automatic logic [CW-1:0] dec(input logic [CW-1:0] v);
    return (v != '0) ? v - CW'(1) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      arrival   <= '0;
      bid_total <= '0;
      ask_total <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_DONE);
      unique case (state)
        S_IDLE: if (start) begin
          r_op    <= op;
          r_side  <= side;
          r_price <= price;
          left    <= quantity;
          r_id    <= order_id;
          filled  <= '0;
          raddr   <= '0;
          rd_vld  <= 1'b0;
          best_vld <= 1'b0;
          free_vld <= 1'b0;
        end
        S_SCAN, S_SCAN_LAST: begin
          rd_vld <= (state == S_SCAN);
          rd_idx <= raddr;
          if (state == S_SCAN) raddr <= raddr + AW'(1);
          if (cand && better) begin
            best_vld   <= 1'b1;
            best_idx   <= rd_idx;
            best_price <= rdata.price;
            best_age   <= age;
            best_qty   <= rdata.qty;
            best_side  <= rdata.side;
            best_id    <= rdata.id;
            best_stamp <= rdata.stamp;
          end
          if (rd_vld && !used[rd_idx] && !free_vld) begin
            free_vld <= 1'b1;
            free_idx <= rd_idx;
          end
          if (state == S_SCAN_LAST && r_op == OP_CANCEL && (best_vld || cand)) begin
            if (cand && better) begin
              used[rd_idx] <= 1'b0;
              if (rdata.side == SIDE_BUY) bid_total <= dec(bid_total);
              else ask_total <= dec(ask_total);
            end else begin
              used[best_idx] <= 1'b0;
              if (best_side == SIDE_BUY) bid_total <= dec(bid_total);
              else ask_total <= dec(ask_total);
            end
          end
        end
        S_FILL: begin
          left   <= left - trade;
          filled <= filled + trade;
          if (best_qty == trade) begin
            used[best_idx] <= 1'b0;
            if (best_side == SIDE_BUY) bid_total <= dec(bid_total);
            else ask_total <= dec(ask_total);
          end
          raddr    <= '0;
          rd_vld   <= 1'b0;
          best_vld <= 1'b0;
          free_vld <= 1'b0;
        end
        S_DONE: begin
          if (r_op == OP_CANCEL) begin
            status     <= best_vld ? ST_CXL_DONE : ST_CXL_ABSNT;
            filled_qty <= '0;
            rested_qty <= '0;
          end else if (left == '0) begin
            status     <= ST_ADD_DONE;
            filled_qty <= filled;
            rested_qty <= '0;
          end else if (free_vld) begin
            status         <= ST_ADD_DONE;
            filled_qty     <= filled;
            rested_qty     <= left;
            used[free_idx] <= 1'b1;
            arrival        <= arrival + STAMP_W'(1);
            if (r_side == SIDE_BUY) bid_total <= bid_total + CW'(1);
            else ask_total <= ask_total + CW'(1);
          end else begin
            status     <= ST_ADD_FULL;
            filled_qty <= filled;
            rested_qty <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // counts after the step, masked to the port width
  always_comb begin
    bid_count = COUNT_W'(bid_total);
    ask_count = COUNT_W'(ask_total);
  end

endmodule
`default_nettype wire

// File: rtl/core/lobm_checker.sv
`default_nettype none
module lobm_checker
  import lobm_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done,
  input wire logic [1:0]         status,
  input wire logic [QTY_W-1:0]   filled_qty,
  input wire logic [QTY_W-1:0]   rested_qty,
  input wire logic [COUNT_W-1:0] bid_count,
  input wire logic [COUNT_W-1:0] ask_count
);

  // a transfer accepted makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted command did not raise busy");

  // result comes once the block is free again
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while still busy");

  // cancels report no quantities
  a_cancel_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_CXL_DONE || status == ST_CXL_ABSNT) |->
      filled_qty == '0 && rested_qty == '0) else $error("cancel with quantity");

  // bid count stays stable unless the block was busy or a result was shown
  a_counts: assert property (@(posedge clk) disable iff (rst)
    !done && !$past(done) && !$past(rst) |-> $stable(bid_count) || $past(busy))
    else $error("counts moved while idle");

endmodule

bind limit_order_book_matcher_core lobm_checker u_lobm_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .filled_qty(filled_qty), .rested_qty(rested_qty),
  .bid_count(bid_count), .ask_count(ask_count)
);
`default_nettype wire

// File: test/tb_limit_order_book_matcher_core.sv
module tb_limit_order_book_matcher_core;
  import lobm_pkg::*;

  localparam int unsigned SLOTS = ORDER_SLOTS_DEF;

  typedef struct {
    logic               op;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [ID_W-1:0]    id;
    bit                 drain;
  } order_t;

  typedef struct {
    status_t            status;
    logic [QTY_W-1:0]   filled;
    logic [QTY_W-1:0]   rested;
    logic [COUNT_W-1:0] bids;
    logic [COUNT_W-1:0] asks;
  } report_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               op;
  logic               side;
  logic [PRICE_W-1:0] price;
  logic [QTY_W-1:0]   quantity;
  logic [ID_W-1:0]    order_id;
  logic               done;
  logic [1:0]         status;
  logic [QTY_W-1:0]   filled_qty;
  logic [QTY_W-1:0]   rested_qty;
  logic [COUNT_W-1:0] bid_count;
  logic [COUNT_W-1:0] ask_count;

  limit_order_book_matcher_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .side(side), .price(price), .quantity(quantity), .order_id(order_id),
    .done(done), .status(status), .filled_qty(filled_qty), .rested_qty(rested_qty),
    .bid_count(bid_count), .ask_count(ask_count)
  );

  // shadow copy of the book
  bit                 bk_used [SLOTS];
  logic [ID_W-1:0]    bk_id   [SLOTS];
  logic               bk_side [SLOTS];
  logic [PRICE_W-1:0] bk_price[SLOTS];
  logic [QTY_W-1:0]   bk_qty  [SLOTS];
  logic [STAMP_W-1:0] bk_stamp[SLOTS];
  logic [STAMP_W-1:0] next_stamp;
  logic [COUNT_W-1:0] bid_total, ask_total;

  order_t  order_q[$];
  report_t report_q[$];
  logic [ID_W-1:0] id_pool[$];
  int errors, transfers, results, fills_seen, full_seen, absent_seen;
  int burst_left, gap_left;

  // remove one resting order
  function automatic void unlink_slot(int s);
    bk_used[s] = 0;
    if (bk_side[s] == SIDE_BUY) bid_total = bid_total - 1;
    else ask_total = ask_total - 1;
  endfunction

  // best crossing resting order opposite to the taker, or SLOTS if none
  function automatic int best_maker(logic tside, logic [PRICE_W-1:0] lim);
    int best;
    logic [PRICE_W-1:0] bp;
    logic [STAMP_W-1:0] bage, age;
    bit better;
    best = SLOTS;
    bp = 0;
    bage = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!bk_used[i] || bk_side[i] == tside) continue;
      if (tside == SIDE_BUY && bk_price[i] > lim) continue;
      if (tside == SIDE_SELL && bk_price[i] < lim) continue;
      age = next_stamp - bk_stamp[i];
      if (best == SLOTS) better = 1;
      else if (bk_price[i] != bp)
        better = (tside == SIDE_BUY) ? (bk_price[i] < bp) : (bk_price[i] > bp);
      else better = age > bage;
      if (better) begin
        best = i;
        bp = bk_price[i];
        bage = age;
      end
    end
    return best;
  endfunction

  // apply one order to the shadow book and return its report
  function automatic report_t match_order(order_t o);
    report_t r;
    int hit, b, fs;
    logic [STAMP_W-1:0] hage, age;
    logic [QTY_W-1:0] left, t;
    r.status = ST_ADD_DONE;
    r.filled = 0;
    r.rested = 0;
    if (o.op == OP_CANCEL) begin
      hit = SLOTS;
      hage = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!bk_used[i] || bk_id[i] != o.id) continue;
        age = next_stamp - bk_stamp[i];
        if (hit == SLOTS || age < hage) begin
          hit = i;
          hage = age;
        end
      end
      if (hit < SLOTS) begin
        unlink_slot(hit);
        r.status = ST_CXL_DONE;
      end else begin
        r.status = ST_CXL_ABSNT;
        absent_seen++;
      end
    end else begin
      left = o.qty;
      while (left != 0) begin
        b = best_maker(o.side, o.price);
        if (b >= SLOTS) break;
        t = (left < bk_qty[b]) ? left : bk_qty[b];
        left -= t;
        bk_qty[b] -= t;
        r.filled += t;
        fills_seen++;
        if (bk_qty[b] == 0) unlink_slot(b);
      end
      if (left != 0) begin
        fs = SLOTS;
        for (int i = 0; i < SLOTS; i++)
          if (!bk_used[i]) begin
            fs = i;
            break;
          end
        if (fs < SLOTS) begin
          bk_used[fs] = 1;
          bk_id[fs] = o.id;
          bk_side[fs] = o.side;
          bk_price[fs] = o.price;
          bk_qty[fs] = left;
          bk_stamp[fs] = next_stamp;
          next_stamp++;
          if (o.side == SIDE_BUY) bid_total++;
          else ask_total++;
          r.rested = left;
        end else begin
          r.status = ST_ADD_FULL;
          full_seen++;
        end
      end
    end
    r.bids = bid_total;
    r.asks = ask_total;
    return r;
  endfunction

  function automatic void push_order(logic o_op, logic o_side, logic [PRICE_W-1:0] p,
                                     logic [QTY_W-1:0] q, logic [ID_W-1:0] id, bit dr);
    order_t o;
    o.op = o_op;
    o.side = o_side;
    o.price = p;
    o.qty = q;
    o.id = id;
    o.drain = dr;
    order_q.insert(order_q.size(), o);
    if (o_op == OP_ADD) id_pool.insert(id_pool.size(), id);
  endfunction

  function automatic logic [31:0] rnd32();
    return $urandom;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if (id_pool.size() != 0 && $urandom_range(0, 9) < 7)
      return id_pool[$urandom_range(0, id_pool.size() - 1)];
    return {rnd32(), rnd32()};
  endfunction

  // random add or cancel around a mid price
  function automatic void push_random(int mid, int spread, int cxl_pct);
    logic [QTY_W-1:0] q;
    if ($urandom_range(0, 99) < cxl_pct) begin
      push_order(OP_CANCEL, $urandom_range(0, 1), rnd32(), rnd32(), pick_id(), 0);
    end else begin
      case ($urandom_range(0, 19))
        0:       q = rnd32();
        1:       q = 0;
        default: q = $urandom_range(1, 60);
      endcase
      if ($urandom_range(0, 29) == 0)
        push_order(OP_ADD, $urandom_range(0, 1), rnd32(), q, {rnd32(), rnd32()}, 0);
      else
        push_order(OP_ADD, $urandom_range(0, 1), mid + $urandom_range(0, 2 * spread) - spread,
                   q, $urandom_range(1, 400), 0);
    end
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // stimulus
  initial begin
    rst = 1;
    // directed: extremes, zero quantity, cancels, duplicates, self trade, time priority
    push_order(OP_ADD, SIDE_BUY, 32'd0, 32'd0, 64'd1, 0);
    push_order(OP_CANCEL, SIDE_BUY, 32'd0, 32'd0, 64'd1, 0);
    push_order(OP_ADD, SIDE_SELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    push_order(OP_ADD, SIDE_BUY, 32'hFFFF_FFFF, 32'd5, 64'd2, 0);
    push_order(OP_ADD, SIDE_BUY, 32'd0, 32'hFFFF_FFFF, 64'd3, 0);
    push_order(OP_ADD, SIDE_SELL, 32'd0, 32'hFFFF_FFFF, 64'd4, 0);
    push_order(OP_CANCEL, SIDE_SELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    push_order(OP_CANCEL, SIDE_SELL, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    push_order(OP_ADD, SIDE_SELL, 32'd100, 32'd10, 64'd10, 0);
    push_order(OP_ADD, SIDE_SELL, 32'd100, 32'd10, 64'd11, 0);
    push_order(OP_ADD, SIDE_SELL, 32'd99, 32'd10, 64'd12, 0);
    push_order(OP_ADD, SIDE_BUY, 32'd100, 32'd15, 64'd13, 0);
    push_order(OP_ADD, SIDE_BUY, 32'd100, 32'd20, 64'd14, 0);
    push_order(OP_ADD, SIDE_SELL, 32'd50, 32'd8, 64'd20, 0);
    push_order(OP_ADD, SIDE_SELL, 32'd50, 32'd8, 64'd20, 0);
    push_order(OP_CANCEL, SIDE_BUY, 32'd0, 32'd0, 64'd20, 0);
    push_order(OP_ADD, SIDE_BUY, 32'd60, 32'd3, 64'd20, 0);
    push_order(OP_ADD, SIDE_BUY, 32'd200, 32'd9, 64'd21, 0);
    push_order(OP_CANCEL, SIDE_SELL, 32'd0, 32'd0, 64'd999, 0);
    push_order(OP_ADD, SIDE_SELL, 32'd1, 32'd100, 64'd22, 0);
    // random: steady trading
    repeat (550) push_random(1000, 15, 25);
    // fill the book from both sides until remainders get dropped
    for (int i = 0; i < 320; i++)
      if (i % 2 == 0) push_order(OP_ADD, SIDE_BUY, 500 + $urandom_range(0, 10),
                                 $urandom_range(1, 20), 1000 + i, 0);
      else push_order(OP_ADD, SIDE_SELL, 1500 + $urandom_range(0, 10),
                      $urandom_range(1, 20), 1000 + i, 0);
    // sweeps across many levels, after the book settles
    push_order(OP_ADD, SIDE_BUY, 1505, 32'd400, 64'd5000, 1);
    push_order(OP_ADD, SIDE_SELL, 505, 32'd400, 64'd5001, 0);
    repeat (60) push_random(1000, 600, 30);
    repeat (120) push_order(OP_CANCEL, SIDE_BUY, 0, 0, 1000 + $urandom_range(0, 330), 0);
    push_order(OP_ADD, SIDE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd5002, 1);
    push_order(OP_ADD, SIDE_SELL, 32'd0, 32'hFFFF_FFFF, 64'd5003, 0);
    // random: mixed widths and wider spread
    repeat (880) push_random(2000, 40, 30);
    start = 0;
    op = OP_ADD;
    side = SIDE_BUY;
    price = 0;
    quantity = 0;
    order_id = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    wait (order_q.size() == 0 && report_q.size() == 0);
    repeat (600) @(posedge clk);
    $display("%0d transfers, %0d results, %0d fills, %0d dropped remainders, %0d absent cancels",
             transfers, results, fills_seen, full_seen, absent_seen);
    $display("book ended with %0d bids and %0d asks, %0d mismatches",
             bid_total, ask_total, errors);
    if (errors == 0 && report_q.size() == 0)
      $display("limit_order_book_matcher_core regression: pass");
    else
      $display("limit_order_book_matcher_core regression: fail");
    $finish;
  end

  // driver: bursts with random gaps, optional drain before an order
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
      burst_left <= 0;
      gap_left <= 0;
      next_stamp = 0;
      bid_total = 0;
      ask_total = 0;
      for (int i = 0; i < SLOTS; i++) bk_used[i] = 0;
    end else begin
      if (start && !busy) begin
        report_q.insert(report_q.size(), match_order(order_q.pop_front()));
        transfers++;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 0;
      end else if (order_q.size() != 0 && !(order_q[0].drain && report_q.size() != 0)
                   && !(start && !busy && burst_left == 0)) begin
        start <= 1;
        op <= order_q[0].op;
        side <= order_q[0].side;
        price <= order_q[0].price;
        quantity <= order_q[0].qty;
        order_id <= order_q[0].id;
        if (start && !busy) burst_left <= burst_left - 1;
      end else begin
        start <= 0;
        if (start && !busy && burst_left == 0) begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
        end
      end
    end
  end

  // monitor: one result per transfer, checked in order
  always @(posedge clk) begin
    report_t e;
    if (!rst && done) begin
      results++;
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, status %0d", $time, status);
      end else begin
        e = report_q.pop_front();
        if (status !== e.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        end
        if (filled_qty !== e.filled) begin
          errors++;
          $display("%0t: filled_qty expected %0d actual %0d", $time, e.filled, filled_qty);
        end
        if (rested_qty !== e.rested) begin
          errors++;
          $display("%0t: rested_qty expected %0d actual %0d", $time, e.rested, rested_qty);
        end
        if (bid_count !== e.bids) begin
          errors++;
          $display("%0t: bid_count expected %0d actual %0d", $time, e.bids, bid_count);
        end
        if (ask_count !== e.asks) begin
          errors++;
          $display("%0t: ask_count expected %0d actual %0d", $time, e.asks, ask_count);
        end
      end
    end
  end

  // run limit
  initial begin
    #400000000;
    $display("limit_order_book_matcher_core regression: fail");
    $finish;
  end

endmodule
